>>> src/mclw_pkg.sv
package mclw_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int ACT_W        = 4;
    localparam int MISS_W       = 3;
    localparam int CNT_W        = 32;
    localparam int CMD_W        = 16;
    localparam int CFG_IDX_W    = 2;

    // Function codes of an input beat
    localparam logic [1:0] FN_TICK      = 2'd0;
    localparam logic [1:0] FN_HEARTBEAT = 2'd1;
    localparam logic [1:0] FN_COMMAND   = 2'd2;

    // Command sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_STOP  = 2'd1;
    localparam logic [1:0] PH_START = 2'd2;

    // Command words
    localparam logic [CMD_W-1:0] CMD_STOP_A  = 16'hEE00;
    localparam logic [CMD_W-1:0] CMD_STOP_B  = 16'h00EE;
    localparam logic [CMD_W-1:0] CMD_START_A = 16'hFF00;
    localparam logic [CMD_W-1:0] CMD_START_B = 16'h00FF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd2;

    localparam logic [CNT_W-1:0]  TIMEOUT_RST = 32'hFFE1FB40;
    localparam logic [MISS_W-1:0] LIMIT_RST   = 3'd3;
    localparam logic [ACT_W-1:0]  ACTIVE_RST  = 4'd3;
    localparam logic [MISS_W-1:0] MISS_SAT    = 3'd7;

    typedef struct packed {
        logic [1:0]       func;
        logic [CH_W-1:0]  channel;
        logic [CMD_W-1:0] command_word;
    } t_in;

    typedef struct packed {
        logic reset_request;
        logic check_done;
        logic running;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0]  timeout_ticks;
        logic [MISS_W-1:0] miss_limit;
        logic [ACT_W-1:0]  active_channels;
    } t_cfg;

    typedef struct packed {
        logic       failed;
        logic       running;
        logic [1:0] phase;
    } t_stat;

endpackage

>>> src/mclw_cfg.sv
module mclw_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mclw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mclw_pkg::CNT_W-1:0]     i_cfg_wdata,
    output mclw_pkg::t_cfg                 o_cfg
);

    mclw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks   <= mclw_pkg::TIMEOUT_RST;
            r_cfg.miss_limit      <= mclw_pkg::LIMIT_RST;
            r_cfg.active_channels <= mclw_pkg::ACTIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mclw_pkg::CFG_TIMEOUT: begin
                    r_cfg.timeout_ticks <= i_cfg_wdata;
                end
                mclw_pkg::CFG_LIMIT: begin
                    r_cfg.miss_limit <= i_cfg_wdata[mclw_pkg::MISS_W-1:0];
                end
                mclw_pkg::CFG_ACTIVE: begin
                    r_cfg.active_channels <= i_cfg_wdata[mclw_pkg::ACT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/mclw_core.sv
module mclw_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  mclw_pkg::t_in  i_item,
    input  mclw_pkg::t_cfg i_cfg,
    output mclw_pkg::t_out o_result,
    output mclw_pkg::t_stat o_stat
);

    logic [mclw_pkg::CNT_W-1:0]  r_countdown, n_countdown;
    logic                        r_running, n_running;
    logic                        r_failed, n_failed;
    logic [1:0]                  r_phase, n_phase;
    logic [mclw_pkg::MISS_W-1:0] r_miss [mclw_pkg::MAX_CHANNELS];
    logic [mclw_pkg::MISS_W-1:0] n_miss [mclw_pkg::MAX_CHANNELS];

    logic [mclw_pkg::CNT_W-1:0]  cd_dec;
    logic [mclw_pkg::ACT_W:0]    n_act;
    logic                        bad;
    logic                        checked;

    // Number of channels examined by a check, clamped to the channel count.
    always_comb begin
        if ({1'b0, i_cfg.active_channels} > (mclw_pkg::ACT_W+1)'(mclw_pkg::MAX_CHANNELS)) begin
            n_act = (mclw_pkg::ACT_W+1)'(mclw_pkg::MAX_CHANNELS);
        end else begin
            n_act = {1'b0, i_cfg.active_channels};
        end
    end

    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < mclw_pkg::MAX_CHANNELS; i++) begin
            if (((mclw_pkg::ACT_W+1)'(i) < n_act) && (r_miss[i] >= i_cfg.miss_limit)) begin
                bad = 1'b1;
            end
        end
    end

    assign cd_dec = r_countdown - 1'b1;

    always_comb begin
        n_countdown = r_countdown;
        n_running   = r_running;
        n_failed    = r_failed;
        n_phase     = r_phase;
        n_miss      = r_miss;
        checked     = 1'b0;
        case (i_item.func)
            mclw_pkg::FN_TICK: begin
                if (r_running) begin
                    if (r_countdown == '0) begin
                        n_failed  = 1'b1;
                        n_running = 1'b0;
                    end else begin
                        n_countdown = cd_dec;
                        if (cd_dec == '0) begin
                            n_failed  = 1'b1;
                            n_running = 1'b0;
                        end else if (cd_dec == (i_cfg.timeout_ticks >> 1)) begin
                            checked = 1'b1;
                            if (bad) begin
                                n_failed  = 1'b1;
                                n_running = 1'b0;
                            end else begin
                                for (int i = 0; i < mclw_pkg::MAX_CHANNELS; i++) begin
                                    if (r_miss[i] != mclw_pkg::MISS_SAT) begin
                                        n_miss[i] = r_miss[i] + 1'b1;
                                    end
                                end
                                n_countdown = i_cfg.timeout_ticks;
                            end
                        end
                    end
                end
            end
            mclw_pkg::FN_HEARTBEAT: begin
                if ({1'b0, i_item.channel} < (mclw_pkg::CH_W+1)'(mclw_pkg::MAX_CHANNELS)) begin
                    n_miss[i_item.channel] = '0;
                end
            end
            mclw_pkg::FN_COMMAND: begin
                if (r_phase == mclw_pkg::PH_STOP
                        && i_item.command_word == mclw_pkg::CMD_STOP_B) begin
                    n_running = 1'b0;
                    n_phase   = mclw_pkg::PH_IDLE;
                end else if (r_phase == mclw_pkg::PH_START
                        && i_item.command_word == mclw_pkg::CMD_START_B) begin
                    n_countdown = i_cfg.timeout_ticks;
                    n_running   = 1'b1;
                    n_phase     = mclw_pkg::PH_IDLE;
                end else if (i_item.command_word == mclw_pkg::CMD_STOP_A) begin
                    n_phase = mclw_pkg::PH_STOP;
                end else if (i_item.command_word == mclw_pkg::CMD_START_A) begin
                    n_phase = mclw_pkg::PH_START;
                end else begin
                    n_phase = mclw_pkg::PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= '0;
            r_running   <= 1'b0;
            r_failed    <= 1'b0;
            r_phase     <= mclw_pkg::PH_IDLE;
            for (int i = 0; i < mclw_pkg::MAX_CHANNELS; i++) begin
                r_miss[i] <= '0;
            end
        end else if (i_fire) begin
            r_countdown <= n_countdown;
            r_running   <= n_running;
            r_failed    <= n_failed;
            r_phase     <= n_phase;
            r_miss      <= n_miss;
        end
    end

    assign o_result.reset_request = n_failed;
    assign o_result.check_done    = checked;
    assign o_result.running       = n_running;

    assign o_stat.failed  = r_failed;
    assign o_stat.running = r_running;
    assign o_stat.phase   = r_phase;

endmodule

>>> src/multi_channel_liveness_watchdog.sv
// A beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle; the input register and the result register
// both advance in every cycle in which the result side is not stalled.
// Reset (synchronous, active low) stops the countdown, clears it, the miss
// counts, the command phase and the sticky reset request, and restores the
// configuration registers to their defaults.
module multi_channel_liveness_watchdog (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mclw_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mclw_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [mclw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mclw_pkg::CNT_W-1:0]     i_cfg_wdata
);

    logic            r_in_valid;
    mclw_pkg::t_in   r_in;
    logic            r_out_valid;
    mclw_pkg::t_out  r_out;
    logic            adv;
    mclw_pkg::t_cfg  cfg;
    mclw_pkg::t_out  result;
    mclw_pkg::t_stat stat;

    // The held beat is executed as soon as the result register can take it.
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    mclw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mclw_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result),
        .o_stat   (stat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.failed |=> stat.failed)
        else $error("reset request cleared without reset");

    a_fail_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(stat.failed) |-> !stat.running)
        else $error("failure did not stop the watchdog");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("held input beat lost before execution");

endmodule
